FILE: hw/rtl/pesp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesp_pkg
// Types, widths and constants shared by the polyline resampler modules.
// ----------------------------------------------------------------------------
package pesp_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  localparam int CRD_W  = 32;           // coordinate width
  localparam int MAG_W  = 32;           // |end - start| fits in 32 bits
  localparam int LEN_W  = MAG_W + 1;    // floor(sqrt(dx^2 + dy^2))
  localparam int DIST_W = 48;           // running arc lengths
  localparam int SPC_W  = 31;           // spacing register
  localparam int ADDR_W = 3;

  localparam logic [DIST_W-1:0] DIST_MAX      = '1;
  localparam logic [SPC_W-1:0]  SPACING_RESET = 31'd12800;
  localparam logic [ADDR_W-1:0] REG_SPACING   = 3'd0;

  typedef struct packed {
    logic signed [CRD_W-1:0] start_x;
    logic signed [CRD_W-1:0] start_y;
    logic signed [CRD_W-1:0] end_x;
    logic signed [CRD_W-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] point_x;
    logic signed [CRD_W-1:0] point_y;
    logic                    last_of_segment;
    logic                    truncated;
  } point_t;

  // One classified segment handed from front to back
  typedef struct packed {
    logic [CRD_W-1:0] base_x;
    logic [CRD_W-1:0] base_y;
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] a0;
    logic [SPC_W-1:0] spacing;
    logic [IDX_W-1:0] last_idx;
    logic             trunc;
  } job_t;

endpackage

FILE: hw/rtl/polyline_equal_spacing_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_equal_spacing_points
// Resamples a polyline, given segment by segment, at an even arc spacing.
// Front: 34-step square root, then 33-step count division if points fall.
// Back: per point a multiply, a 32-step paired division and a round.
// A two-entry queue lets the front classify while the back emits.
// Synchronous reset: spacing returns to 12800, arc lengths to zero, queue empty.
// ----------------------------------------------------------------------------
module polyline_equal_spacing_points import pesp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              seg_valid,
  output logic              seg_stall,
  input  seg_t              seg,
  output logic              pt_valid,
  input  logic              pt_stall,
  output point_t            pt
);

  logic [SPC_W-1:0] spacing;
  logic             q_push, q_full;
  job_t             wr_job, rd_job;
  logic             q_pop, q_empty;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SPACING) ? {1'b0, spacing} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_SPACING)) begin
      spacing <= pwdata[SPC_W-1:0];
    end
  end

  pesp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .spacing   (spacing),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg       (seg),
    .job_push  (q_push),
    .job_full  (q_full),
    .job       (wr_job)
  );

  pesp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_job (rd_job)
  );

  pesp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (q_empty),
    .job_head  (rd_job),
    .job_pop   (q_pop),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt        (pt)
  );

  a_trunc_on_last: assert property (@(posedge clk) disable iff (rst)
    pt_valid && pt.truncated |-> pt.last_of_segment)
    else $error("truncated beat is not the last of its segment");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("segment queue written while full");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_stall |=> seg_stall)
    else $error("front took a segment without going busy");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("segment queue read while empty");

endmodule

FILE: hw/rtl/pesp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesp_front
// Takes a segment, finds its length by an iterative square root, decides
// whether any point falls on it, counts the points by iterative division and
// keeps the running arc lengths. Emitting segments are queued for the back.
// ----------------------------------------------------------------------------
module pesp_front import pesp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [SPC_W-1:0] spacing,
  input  logic             seg_valid,
  output logic             seg_stall,
  input  seg_t             seg,
  output logic             job_push,
  input  logic             job_full,
  output job_t             job
);

  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_SQ   = 4'd1;
  localparam logic [3:0] F_SUM  = 4'd2;
  localparam logic [3:0] F_ROOT = 4'd3;
  localparam logic [3:0] F_CHK  = 4'd4;
  localparam logic [3:0] F_OFS  = 4'd5;
  localparam logic [3:0] F_NUM  = 4'd6;
  localparam logic [3:0] F_DIV  = 4'd7;
  localparam logic [3:0] F_PUSH = 4'd8;

  localparam int RAD_W      = 2 * (LEN_W + 1);   // radicand padded to even bits
  localparam int RREM_W     = LEN_W + 3;
  localparam int ROOT_STEPS = LEN_W + 1;
  localparam int DIV_STEPS  = LEN_W;
  localparam int CNT_W      = $clog2(ROOT_STEPS + 1);

  logic [3:0]          state;
  logic [CRD_W-1:0]    sx, sy;
  logic                neg_x, neg_y;
  logic [MAG_W-1:0]    mx, my;
  logic [2*MAG_W-1:0]  sq_x, sq_y;
  logic [RAD_W-1:0]    rad;
  logic [RREM_W-1:0]   rrem;
  logic [LEN_W:0]      root;
  logic [CNT_W-1:0]    cnt;
  logic [SPC_W-1:0]    s_r;
  logic [LEN_W-1:0]    len, a0, u, num, dq;
  logic [SPC_W-1:0]    drem;
  logic [DIST_W:0]     target_r;
  logic                short_r;
  logic [DIST_W-1:0]   placed, walked;

  logic [CRD_W:0]      dx, dy, dx_abs, dy_abs;
  logic [RREM_W-1:0]   r_cand, r_trial;
  logic [SPC_W:0]      d_cand;
  logic [DIST_W:0]     target_c, reach_c, walk_sum, gap;
  logic [DIST_W+1:0]   placed_sum;
  logic [DIST_W-1:0]   walked_next, placed_next;
  logic                trunc;

  always_comb begin
    dx       = {seg.end_x[CRD_W-1], seg.end_x} - {seg.start_x[CRD_W-1], seg.start_x};
    dy       = {seg.end_y[CRD_W-1], seg.end_y} - {seg.start_y[CRD_W-1], seg.start_y};
    dx_abs   = dx[CRD_W] ? ((CRD_W+1)'(0) - dx) : dx;
    dy_abs   = dy[CRD_W] ? ((CRD_W+1)'(0) - dy) : dy;
    r_cand   = {rrem[RREM_W-3:0], rad[RAD_W-1 -: 2]};
    r_trial  = {root[RREM_W-3:0], 2'b01};
    d_cand   = {drem, num[LEN_W-1]};
    target_c = {1'b0, placed} + {{(DIST_W+1-SPC_W){1'b0}}, s_r};
    reach_c  = {1'b0, walked} + {{(DIST_W+1-LEN_W){1'b0}}, len};
    walk_sum = reach_c;
    walked_next = walk_sum[DIST_W] ? DIST_MAX : walk_sum[DIST_W-1:0];
    gap      = target_r - {1'b0, walked};
    placed_sum = {1'b0, target_r} + {{(DIST_W+2-LEN_W){1'b0}}, u}
               - {{(DIST_W+2-SPC_W){1'b0}}, drem};
    placed_next = (placed_sum[DIST_W+1:DIST_W] != 2'b00) ? DIST_MAX
                                                         : placed_sum[DIST_W-1:0];
    trunc    = dq >= LEN_W'(MAX_POINTS);
  end

  assign seg_stall = (state != F_IDLE);
  assign job_push  = (state == F_PUSH) && !job_full;

  always_comb begin
    job.base_x   = sx;
    job.base_y   = sy;
    job.neg_x    = neg_x;
    job.neg_y    = neg_y;
    job.mag_x    = mx;
    job.mag_y    = my;
    job.len      = len;
    job.a0       = a0;
    job.spacing  = s_r;
    job.last_idx = trunc ? IDX_W'(MAX_POINTS - 1) : dq[IDX_W-1:0];
    job.trunc    = trunc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      placed <= '0;
      walked <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (seg_valid) begin
            sx    <= seg.start_x;
            sy    <= seg.start_y;
            neg_x <= dx[CRD_W];
            neg_y <= dy[CRD_W];
            mx    <= dx_abs[MAG_W-1:0];
            my    <= dy_abs[MAG_W-1:0];
            s_r   <= (spacing == '0) ? SPC_W'(1) : spacing;
            state <= F_SQ;
          end
        end
        F_SQ: begin
          sq_x  <= mx * mx;
          sq_y  <= my * my;
          state <= F_SUM;
        end
        F_SUM: begin
          rad   <= RAD_W'({1'b0, sq_x} + {1'b0, sq_y});
          rrem  <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= F_ROOT;
        end
        F_ROOT: begin
          // one result bit per beat, two radicand bits consumed
          rad <= {rad[RAD_W-3:0], 2'b00};
          if (r_cand >= r_trial) begin
            rrem <= r_cand - r_trial;
            root <= {root[LEN_W-1:0], 1'b1};
          end else begin
            rrem <= r_cand;
            root <= {root[LEN_W-1:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
            state <= F_CHK;
          end
        end
        F_CHK: begin
          len      <= root[LEN_W-1:0];
          target_r <= target_c;
          short_r  <= (root[LEN_W-1:0] == '0) ||
                      (target_c > ({1'b0, walked} +
                                   {{(DIST_W+1-LEN_W){1'b0}}, root[LEN_W-1:0]}));
          state    <= F_OFS;
        end
        F_OFS: begin
          if (short_r) begin
            walked <= walked_next;
            state  <= F_IDLE;
          end else begin
            // saturated sums can leave target behind walked: start at offset zero
            a0    <= (target_r >= {1'b0, walked}) ? gap[LEN_W-1:0] : '0;
            state <= F_NUM;
          end
        end
        F_NUM: begin
          u     <= len - a0;
          num   <= len - a0;
          dq    <= '0;
          drem  <= '0;
          cnt   <= '0;
          state <= F_DIV;
        end
        F_DIV: begin
          num <= {num[LEN_W-2:0], 1'b0};
          if (d_cand >= {1'b0, s_r}) begin
            drem <= SPC_W'(d_cand - {1'b0, s_r});
            dq   <= {dq[LEN_W-2:0], 1'b1};
          end else begin
            drem <= d_cand[SPC_W-1:0];
            dq   <= {dq[LEN_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!job_full) begin
            placed <= placed_next;
            walked <= walked_next;
            state  <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/pesp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesp_queue
// Two-entry queue of classified segments between front and back.
// ----------------------------------------------------------------------------
module pesp_queue import pesp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t rd_job
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pesp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesp_back
// Places the points of one queued segment: per point a multiply, then two
// restoring divisions by the segment length side by side, rounded half up.
// ----------------------------------------------------------------------------
module pesp_back import pesp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   job_empty,
  input  job_t   job_head,
  output logic   job_pop,
  output logic   pt_valid,
  input  logic   pt_stall,
  output point_t pt
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_LOAD = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  localparam int PROD_W    = LEN_W + MAG_W;
  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  logic [2:0]        state;
  job_t              cur;
  logic [LEN_W-1:0]  a;
  logic [IDX_W-1:0]  idx;
  logic [PROD_W-1:0] px, py;
  logic [LEN_W-1:0]  rx, ry;
  logic [MAG_W-1:0]  lx, ly, qx, qy;
  logic [CNT_W-1:0]  cnt;

  logic [LEN_W:0]    cx, cy, dlen;
  logic [MAG_W-1:0]  qx_rnd, qy_rnd;
  logic              last;
  logic              pt_load;

  always_comb begin
    dlen   = {1'b0, cur.len};
    cx     = {rx, lx[MAG_W-1]};
    cy     = {ry, ly[MAG_W-1]};
    qx_rnd = qx + MAG_W'({rx, 1'b0} >= dlen);
    qy_rnd = qy + MAG_W'({ry, 1'b0} >= dlen);
    last   = (idx == cur.last_idx);
  end

  assign job_pop = (state == B_IDLE) && !job_empty;
  assign pt_load = (state == B_OUT) && (!pt_valid || !pt_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      pt_valid <= 1'b0;
    end else begin
      if (pt_load) begin
        pt_valid <= 1'b1;
      end else if (!pt_stall) begin
        pt_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!job_empty) begin
            cur   <= job_head;
            a     <= job_head.a0;
            idx   <= '0;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          px    <= a * cur.mag_x;
          py    <= a * cur.mag_y;
          state <= B_LOAD;
        end
        B_LOAD: begin
          // quotient is at most the magnitude, so the top bits start below len
          rx    <= px[PROD_W-1:MAG_W];
          ry    <= py[PROD_W-1:MAG_W];
          lx    <= px[MAG_W-1:0];
          ly    <= py[MAG_W-1:0];
          qx    <= '0;
          qy    <= '0;
          cnt   <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          lx <= {lx[MAG_W-2:0], 1'b0};
          ly <= {ly[MAG_W-2:0], 1'b0};
          if (cx >= dlen) begin
            rx <= LEN_W'(cx - dlen);
            qx <= {qx[MAG_W-2:0], 1'b1};
          end else begin
            rx <= cx[LEN_W-1:0];
            qx <= {qx[MAG_W-2:0], 1'b0};
          end
          if (cy >= dlen) begin
            ry <= LEN_W'(cy - dlen);
            qy <= {qy[MAG_W-2:0], 1'b1};
          end else begin
            ry <= cy[LEN_W-1:0];
            qy <= {qy[MAG_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (pt_load) begin
            pt.point_x         <= cur.neg_x ? (cur.base_x - qx_rnd) : (cur.base_x + qx_rnd);
            pt.point_y         <= cur.neg_y ? (cur.base_y - qy_rnd) : (cur.base_y + qy_rnd);
            pt.last_of_segment <= last;
            pt.truncated       <= last && cur.trunc;
            if (last) begin
              state <= B_IDLE;
            end else begin
              a     <= a + {{(LEN_W-SPC_W){1'b0}}, cur.spacing};
              idx   <= idx + 1'b1;
              state <= B_MUL;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the polyline resampler against an in-bench arc-length predictor.
// Directed segments cover extremes, short and zero-length segments and the
// point cap; random polylines follow, over several spacings,
// with random gaps on the segment side and random stalls on the point side.
// ----------------------------------------------------------------------------
module tb;
  import pesp_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              seg_valid = 1'b0;
  logic              seg_stall;
  seg_t              seg = '0;
  logic              pt_valid;
  logic              pt_stall = 1'b0;
  point_t            pt;

  polyline_equal_spacing_points u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // resampler state mirror
  logic [SPC_W-1:0]  spacing_reg;
  logic [DIST_W-1:0] placed_dist, walked_dist;

  seg_t   seg_q[$];
  point_t point_q[$];
  int     fails = 0;
  longint cycles = 0;
  int     seg_gap = 0, pt_gap = 0;

  function automatic logic [DIST_W-1:0] dist_sat(logic [63:0] a);
    return (a > 64'(DIST_MAX)) ? DIST_MAX : a[DIST_W-1:0];
  endfunction

  // start + |d|*a/len rounded half away from start
  function automatic logic [31:0] along(logic signed [63:0] base,
                                        logic signed [63:0] d,
                                        logic [63:0] a, logic [63:0] len);
    logic [63:0]  mag;
    logic [127:0] prod, q, r;
    mag  = d < 0 ? -d : d;
    prod = 128'(a) * 128'(mag);
    q = prod / len;
    r = prod % len;
    if (r >= len - r) q++;
    return d < 0 ? 32'(base - q[63:0]) : 32'(base + q[63:0]);
  endfunction

  function automatic void predict_points(seg_t s);
    logic signed [63:0] sx, sy, dx, dy;
    logic [63:0]  mx, my, spc, len, tgt, a0, n, emit, root, rem, trial;
    logic [127:0] sq;
    point_t p;
    sx = 64'(s.start_x); sy = 64'(s.start_y);
    dx = 64'(s.end_x) - sx; dy = 64'(s.end_y) - sy;
    spc = spacing_reg == 0 ? 64'd1 : 64'(spacing_reg);
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    sq = 128'(mx) * mx + 128'(my) * my;
    root = 0; rem = 0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | 64'(sq[2*i +: 2]);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial; root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    len = root;
    tgt = 64'(placed_dist) + spc;
    if (len == 0 || tgt > 64'(walked_dist) + len) begin
      walked_dist = dist_sat(64'(walked_dist) + len);
      return;
    end
    a0 = tgt >= 64'(walked_dist) ? tgt - 64'(walked_dist) : 64'd0;
    n = (len - a0) / spc + 1;
    emit = n > MAX_POINTS ? 64'(MAX_POINTS) : n;
    for (longint i = 0; i < emit; i++) begin
      p.point_x = along(sx, dx, a0 + i * spc, len);
      p.point_y = along(sy, dy, a0 + i * spc, len);
      p.last_of_segment = (i + 1 == emit);
      p.truncated = (i + 1 == emit) && n > MAX_POINTS;
      point_q = {point_q, p};
    end
    placed_dist = dist_sat(64'(placed_dist) + n * spc);
    walked_dist = dist_sat(64'(walked_dist) + len);
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (seg_valid && !seg_stall) begin
        predict_points(seg);
        void'(seg_q.pop_front());
        seg_gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) seg_gap = 0;
      end
      if (seg_valid && seg_stall) begin
        // hold the beat
      end else if (seg_gap > 0) begin
        seg_gap--;
        seg_valid <= 1'b0;
      end else if (seg_q.size() > 0) begin
        seg_valid <= 1'b1;
        seg <= seg_q[0];
      end else begin
        seg_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (pt_valid && !pt_stall) begin
        if (point_q.size() == 0) begin
          $display("%0t unexpected point: got %h", $time, pt);
          fails++;
        end else begin
          if (pt !== point_q[0]) begin
            $display("%0t point mismatch: exp x=%h y=%h l=%b t=%b got x=%h y=%h l=%b t=%b",
                     $time, point_q[0].point_x, point_q[0].point_y,
                     point_q[0].last_of_segment, point_q[0].truncated,
                     pt.point_x, pt.point_y, pt.last_of_segment, pt.truncated);
            fails++;
          end
          void'(point_q.pop_front());
        end
        pt_gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) pt_gap = 0;
      end
      if (pt_gap > 0) begin
        pt_gap--;
        pt_stall <= 1'b1;
      end else begin
        pt_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 64'd3000000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic write_spacing(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_SPACING; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    spacing_reg = v[SPC_W-1:0];
  endtask

  task automatic drain();
    while (seg_q.size() > 0 || seg_valid || point_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic seg_t mk(int sx, int sy, int ex, int ey);
    seg_t s;
    s.start_x = sx; s.start_y = sy; s.end_x = ex; s.end_y = ey;
    return s;
  endfunction

  // mostly chained polylines with small steps, some wild ones
  task automatic random_segs(int count, int step);
    int x, y, nx, ny;
    x = $urandom; y = $urandom;
    x = x >>> 4; y = y >>> 4;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        seg_q = {seg_q, mk($urandom, $urandom, $urandom, $urandom)};
      end else begin
        nx = x + $signed($urandom_range(0, 2 * step)) - step;
        ny = y + $signed($urandom_range(0, 2 * step)) - step;
        seg_q = {seg_q, mk(x, y, nx, ny)};
        x = nx; y = ny;
      end
    end
  endtask

  initial begin
    spacing_reg = SPACING_RESET;
    placed_dist = '0;
    walked_dist = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed
    seg_q = {seg_q, mk(0, 0, 0, 0)};                     // zero length
    seg_q = {seg_q, mk(0, 0, 100, 0)};                   // short, adds length
    seg_q = {seg_q, mk(100, 0, 100, 40000)};             // crosses join
    seg_q = {seg_q, mk(0, 0, -30000, -30000)};
    seg_q = {seg_q, mk(0, 0, 12800 * 100, 5)};           // capped
    seg_q = {seg_q, mk(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff)};
    seg_q = {seg_q, mk(32'sh7fffffff, 0, 32'sh80000000, 0)};
    seg_q = {seg_q, mk(-1, -1, -1, -1)};
    drain();

    write_spacing(32'd0);                                // acts as one
    seg_q = {seg_q, mk(0, 0, 20, 30)};
    seg_q = {seg_q, mk(0, 0, 3, -4)};
    drain();

    write_spacing(32'h7fffffff);                         // widest spacing
    seg_q = {seg_q, mk(32'sh80000000, 0, 32'sh7fffffff, 0)};
    seg_q = {seg_q, mk(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff)};
    repeat (6)
      seg_q = {seg_q, mk(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000)};
    seg_q = {seg_q, mk(0, 0, 1, 1)};
    drain();

    write_spacing(32'd1);
    random_segs(40, 600);
    drain();

    write_spacing(32'd256);
    random_segs(50, 8000);
    drain();

    write_spacing(32'd12800);
    random_segs(60, 200000);
    drain();

    write_spacing($urandom_range(1000, 100000));
    random_segs(50, 300000);
    drain();

    if (fails == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

FILE: polyline_equal_spacing_points.f
hw/rtl/pesp_pkg.sv
hw/rtl/pesp_front.sv
hw/rtl/pesp_queue.sv
hw/rtl/pesp_back.sv
hw/rtl/polyline_equal_spacing_points.sv
dv/tb.sv
